// ===== rtl/ltcs_pkg.sv =====
package ltcs_pkg;

   localparam int ENTRIES_DEFAULT = 8;

   // Function codes
   localparam logic [1:0] FUNC_MEASURE  = 2'd0;
   localparam logic [1:0] FUNC_WR_UPPER = 2'd1;
   localparam logic [1:0] FUNC_WR_LOWER = 2'd2;
   localparam logic [1:0] FUNC_SELECT   = 2'd3;

   // Quantity codes
   localparam logic [2:0] QTY_TIMEOUT = 3'd0;
   localparam logic [2:0] QTY_VOLT    = 3'd1;
   localparam logic [2:0] QTY_CURRENT = 3'd2;
   localparam logic [2:0] QTY_CHARGE  = 3'd3;
   localparam logic [2:0] QTY_TEMP    = 3'd4;
   localparam logic [2:0] QTY_COUNT   = 3'd5;

   localparam int SIDE_SLOTS    = 5;
   localparam int SLOTS_PER_ROW = 2 * SIDE_SLOTS;

   typedef logic [3:0] slot_idx_type;

   // Slot positions inside one row: upper side first, then lower side
   localparam slot_idx_type SLOT_HI_TIME = 4'd0;
   localparam slot_idx_type SLOT_HI_VOLT = 4'd1;
   localparam slot_idx_type SLOT_HI_CURR = 4'd2;
   localparam slot_idx_type SLOT_HI_CHRG = 4'd3;
   localparam slot_idx_type SLOT_HI_TEMP = 4'd4;
   localparam slot_idx_type SLOT_LO_VOLT = 4'd6;
   localparam slot_idx_type SLOT_LO_CURR = 4'd7;
   localparam slot_idx_type SLOT_LO_CHRG = 4'd8;
   localparam slot_idx_type SLOT_LO_TEMP = 4'd9;

   localparam logic [31:0] DEFAULT_DELTA = 32'(3600 * 1000);
   localparam logic [31:0] HI_VOLT_MV    = 32'(5 * 1380);
   localparam logic [31:0] HI_CURR_MA    = 32'd1000;
   localparam logic [31:0] HI_TEMP_CENTI = 32'(5200 - 500);
   localparam logic [31:0] LO_VOLT_MV    = 32'(5 * 200);
   localparam logic [31:0] LO_TEMP_CENTI = 32'd0;
   localparam logic [7:0]  DEFAULT_ACT   = 8'd1;
   localparam logic [7:0]  DEFAULT_ENTRY = 8'd2;

   typedef struct packed {
      logic [7:0]  action;
      logic [31:0] value;
   } limit_slot_type;

   typedef limit_slot_type [SLOTS_PER_ROW-1:0] row_type;

   typedef struct packed {
      logic           en;
      slot_idx_type   slot;
      limit_slot_type data;
   } limit_wr_type;

   typedef struct packed {
      logic [1:0]         func;
      logic [2:0]         entry;
      logic [2:0]         quantity;
      logic [7:0]         limit_action;
      logic [31:0]        limit_value;
      logic [31:0]        now_ms;
      logic [15:0]        volt_mv;
      logic signed [15:0] current_ma;
      logic signed [15:0] charge_raw;
      logic signed [15:0] temp_centi;
      logic               ac_present;
   } req_type;

   typedef struct packed {
      logic       switched;
      logic [2:0] active_entry;
      logic [7:0] trip_action;
   } rsp_type;

   // Power-up contents of the NiMH entry
   function automatic row_type default_row();
      row_type r;
      r = '0;
      r[SLOT_HI_TIME].value  = DEFAULT_DELTA;
      r[SLOT_HI_VOLT].action = DEFAULT_ACT;
      r[SLOT_HI_VOLT].value  = HI_VOLT_MV;
      r[SLOT_HI_CURR].action = DEFAULT_ACT;
      r[SLOT_HI_CURR].value  = HI_CURR_MA;
      r[SLOT_HI_TEMP].action = DEFAULT_ACT;
      r[SLOT_HI_TEMP].value  = HI_TEMP_CENTI;
      r[SLOT_LO_VOLT].action = DEFAULT_ACT;
      r[SLOT_LO_VOLT].value  = LO_VOLT_MV;
      r[SLOT_LO_TEMP].action = DEFAULT_ACT;
      r[SLOT_LO_TEMP].value  = LO_TEMP_CENTI;
      return r;
   endfunction

endpackage

// ===== rtl/ltcs_limit_mem.sv =====
module ltcs_limit_mem #(
   parameter int ENTRIES = ltcs_pkg::ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ltcs_pkg::limit_wr_type        wr,
   input  logic [$clog2(ENTRIES)-1:0]    wr_addr,
   input  logic                          rd_en,
   input  logic [$clog2(ENTRIES)-1:0]    rd_addr,
   output ltcs_pkg::row_type             rd_data
);
   import ltcs_pkg::*;

   row_type             mem [ENTRIES];
   logic [ENTRIES-1:0]  valid_ff;
   row_type             rd_row_ff;
   logic                rd_valid_ff;
   logic                rd_dflt_ff;
   row_type             wr_row;
   logic                wr_dflt;
   logic                rd_dflt;

   // Only the NiMH entry powers up nonzero, and only when it exists
   assign wr_dflt = (ENTRIES > 2) && (8'(wr_addr) == DEFAULT_ENTRY);
   assign rd_dflt = (ENTRIES > 2) && (8'(rd_addr) == DEFAULT_ENTRY);

   // First write to a row lays the whole power-up row down with one slot replaced
   always_comb begin
      wr_row = wr_dflt ? default_row() : '0;
      wr_row[wr.slot] = wr.data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         if (valid_ff[wr_addr]) begin
            mem[wr_addr][wr.slot] <= wr.data;
         end else begin
            mem[wr_addr] <= wr_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff   <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         rd_dflt_ff  <= rd_dflt;
      end
   end

   assign rd_data = rd_valid_ff ? rd_row_ff : (rd_dflt_ff ? default_row() : '0);

endmodule

// ===== rtl/ltcs_eval.sv =====
module ltcs_eval (
   input  ltcs_pkg::row_type  row,
   input  logic [31:0]        deadline_ms,
   input  ltcs_pkg::req_type  meas,
   output logic [7:0]         trip_action
);
   import ltcs_pkg::*;

   logic [31:0] remain;

   assign remain = deadline_ms - meas.now_ms;

   // Fixed priority: deadline, upper limits, lower limits
   always_comb begin
      trip_action = '0;
      if (row[SLOT_HI_TIME].action != '0 && remain[31]) begin
         trip_action = row[SLOT_HI_TIME].action;
      end else if (row[SLOT_HI_VOLT].action != '0
                   && meas.volt_mv > row[SLOT_HI_VOLT].value[15:0]) begin
         trip_action = row[SLOT_HI_VOLT].action;
      end else if (row[SLOT_HI_CURR].action != '0
                   && meas.current_ma > $signed(row[SLOT_HI_CURR].value[15:0])) begin
         trip_action = row[SLOT_HI_CURR].action;
      end else if (row[SLOT_HI_CHRG].action != '0
                   && meas.charge_raw > $signed(row[SLOT_HI_CHRG].value[15:0])) begin
         trip_action = row[SLOT_HI_CHRG].action;
      end else if (row[SLOT_HI_TEMP].action != '0
                   && meas.temp_centi > $signed(row[SLOT_HI_TEMP].value[15:0])) begin
         trip_action = row[SLOT_HI_TEMP].action;
      end else if (row[SLOT_LO_VOLT].action != '0
                   && meas.volt_mv < row[SLOT_LO_VOLT].value[15:0]) begin
         trip_action = row[SLOT_LO_VOLT].action;
      end else if (row[SLOT_LO_CURR].action != '0
                   && meas.current_ma < $signed(row[SLOT_LO_CURR].value[15:0])) begin
         trip_action = row[SLOT_LO_CURR].action;
      end else if (row[SLOT_LO_CHRG].action != '0
                   && meas.charge_raw < $signed(row[SLOT_LO_CHRG].value[15:0])) begin
         trip_action = row[SLOT_LO_CHRG].action;
      end else if (row[SLOT_LO_TEMP].action != '0
                   && meas.temp_centi < $signed(row[SLOT_LO_TEMP].value[15:0])) begin
         trip_action = row[SLOT_LO_TEMP].action;
      end
   end

endmodule

// ===== rtl/limit_table_charge_scheduler_top.sv =====
// Response: registered at the acceptance edge, into the skid slot while the output is stalled.
// Throughput: one transaction per cycle while the skid slot is empty; a transaction that switches the active entry (a
// tripped limit or a select) holds req_ready low for one cycle while the new row is read
// from the limit table (synchronous read port, separate write port).
// Reset: synchronous, active high; per-row valid bits make the table read as its power-up
// contents at once, so there is no clearing pass.
module limit_table_charge_scheduler_top #(
   parameter int ENTRIES = ltcs_pkg::ENTRIES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ltcs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ltcs_pkg::rsp_type rsp_data
);
   import ltcs_pkg::*;

   localparam int          EW        = $clog2(ENTRIES);
   localparam logic [7:0]  CUR_RESET = 8'(2 % ENTRIES);
   localparam int          RECIP     = (65536 + ENTRIES - 1) / ENTRIES;

   // Reduce an 8-bit value mod ENTRIES: the quotient comes from a reciprocal
   // multiply, which is exact for every 8-bit value, and its multiple is subtracted
   function automatic logic [7:0] mod_entries(input logic [7:0] v);
      logic [23:0] prod;
      logic [7:0]  quot;
      logic [15:0] back;
      logic [15:0] rem;
      prod = 24'(v) * 24'(RECIP);
      quot = prod[23:16];
      back = 16'(quot) * 16'(ENTRIES);
      rem  = 16'(v) - back;
      return rem[7:0];
   endfunction

   // Architectural state outside the table
   logic [EW-1:0] cur_ff, cur_in;
   logic [31:0]   deadline_ff, deadline_in;
   logic [31:0]   last_time_ff, last_time_in;
   // Copy of the active entry's row; refilled from the table after each switch
   row_type       cache_ff, cache_in;
   logic          fetch_ff, fetch_in;

   // Response register plus skid slot
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       skid_ff, skid_in;
   logic          skid_valid_ff, skid_valid_in;

   logic          accept;
   logic          is_meas, is_write, is_select;
   logic [7:0]    ent_wide, trip_wide;
   logic [EW-1:0] ent_mod, trip_mod, new_entry;
   logic [7:0]    eval_trip, trip;
   logic          do_switch;
   limit_wr_type  wr;
   row_type       rd_row;
   rsp_type       result;
   logic          rsp_pop;

   assign req_ready = !fetch_ff && !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_pop   = rsp_valid_ff && rsp_ready;

   always_comb begin
      is_meas   = 1'b0;
      is_write  = 1'b0;
      is_select = 1'b0;
      unique case (req_data.func)
         FUNC_MEASURE:                 is_meas   = 1'b1;
         FUNC_WR_UPPER, FUNC_WR_LOWER: is_write  = 1'b1;
         FUNC_SELECT:                  is_select = 1'b1;
         default:                      is_meas   = 1'b0;
      endcase
   end

   assign ent_wide  = mod_entries(8'(req_data.entry));
   assign ent_mod   = ent_wide[EW-1:0];

   ltcs_eval u_eval (
      .row         (cache_ff),
      .deadline_ms (deadline_ff),
      .meas        (req_data),
      .trip_action (eval_trip)
   );

   // Without external power a measurement checks nothing
   assign trip      = (is_meas && req_data.ac_present) ? eval_trip : '0;
   assign trip_wide = mod_entries(trip);
   assign trip_mod  = trip_wide[EW-1:0];

   assign do_switch = accept && (is_select || trip != '0);
   assign new_entry = is_select ? ent_mod : trip_mod;

   // Load one limit slot; ignore quantities past temperature
   always_comb begin
      wr.en        = accept && is_write && (req_data.quantity < QTY_COUNT);
      wr.slot      = (req_data.func == FUNC_WR_LOWER)
                     ? 4'(req_data.quantity) + 4'(SIDE_SLOTS)
                     : 4'(req_data.quantity);
      wr.data.action = req_data.limit_action;
      wr.data.value  = req_data.limit_value;
   end

   ltcs_limit_mem #(
      .ENTRIES (ENTRIES)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .wr_addr (ent_mod),
      .rd_en   (do_switch),
      .rd_addr (new_entry),
      .rd_data (rd_row)
   );

   always_comb begin
      cur_in       = cur_ff;
      deadline_in  = deadline_ff;
      last_time_in = last_time_ff;
      cache_in     = cache_ff;
      fetch_in     = do_switch;
      if (fetch_ff) begin
         // New row has arrived: refill the copy and re-arm the deadline
         cache_in    = rd_row;
         deadline_in = last_time_ff + rd_row[SLOT_HI_TIME].value;
      end else begin
         if (accept && is_meas) begin
            last_time_in = req_data.now_ms;
         end
         if (do_switch) begin
            cur_in = new_entry;
         end
         // Keep the copy coherent with writes to the active entry
         if (wr.en && ent_mod == cur_ff) begin
            cache_in[wr.slot] = wr.data;
         end
      end
   end

   always_comb begin
      result.switched     = do_switch;
      result.active_entry = do_switch ? 3'(8'(new_entry)) : 3'(8'(cur_ff));
      result.trip_action  = trip;
   end

   // Hold a response in the skid slot while the output is stalled
   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_pop) begin
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || rsp_pop) begin
            rsp_in       = result;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff        <= CUR_RESET[EW-1:0];
         deadline_ff   <= DEFAULT_DELTA;
         last_time_ff  <= '0;
         cache_ff      <= (8'(CUR_RESET) == DEFAULT_ENTRY) ? default_row() : '0;
         fetch_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         cur_ff        <= cur_in;
         deadline_ff   <= deadline_in;
         last_time_ff  <= last_time_in;
         cache_ff      <= cache_in;
         fetch_ff      <= fetch_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== tb/sv/limit_table_charge_scheduler_top_tb.sv =====
module limit_table_charge_scheduler_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ltcs_pkg::*;

   localparam int ENTRIES          = ENTRIES_DEFAULT;
   localparam int SLOT_COUNT       = ENTRIES * SLOTS_PER_ROW;
   localparam int SIDE_UPPER       = 0;
   localparam int SIDE_LOWER       = 1;
   localparam int RANDOM_ITEMS     = 1500;
   localparam int DIRECTED_ROWS    = 25;
   localparam int IDLE_LIMIT       = 5000;
   localparam int TAIL_CYCLES      = 10;
   localparam int PRESSURE_AT      = 500;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int REPORT_LIMIT     = 10;

   // Quantity code past the last valid one; a write with it must be dropped
   localparam logic [2:0] QTY_BAD = 3'd7;

   // Directed rows either carry a hand-typed response or defer to the predictor
   localparam bit TYPED     = 1'b1;
   localparam bit PREDICTED = 1'b0;
   localparam rsp_type ANY_RSP = '0;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } stim_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Scheduler state as the testbench sees it
   logic [7:0]  limit_action_tbl [SLOT_COUNT];
   logic [31:0] limit_value_tbl  [SLOT_COUNT];
   int          sched_entry;
   logic [31:0] sched_deadline_ms;
   logic [31:0] sched_last_ms;

   rsp_type     pending_outcomes [$];
   int          failure_count     = 0;
   int          accepted_count    = 0;
   int          idle_cycles       = 0;
   int          req_quiet_left    = 0;
   int          rsp_quiet_left    = 0;
   bit          long_hold_pending = 1'b0;
   logic [31:0] gen_time_ms       = 32'd1000;

   // Directed part: power-up table behavior, trip paths, extremes, writes
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // Power-up entry, readings inside every limit: nothing trips
      '{'{FUNC_MEASURE, 3'd0, QTY_TIMEOUT, 8'h00, 32'h0, 32'd0,
          16'd3000, 16'h0000, 16'h0000, 16'd2500, 1'b1}, TYPED, '{1'b0, 3'd2, 8'h00}},
      // No external power: extreme readings are ignored
      '{'{FUNC_MEASURE, 3'd0, QTY_TIMEOUT, 8'h00, 32'h0, 32'd100,
          16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0}, TYPED, '{1'b0, 3'd2, 8'h00}},
      // Upper voltage trips at full scale
      '{'{FUNC_MEASURE, 3'd0, QTY_TIMEOUT, 8'h00, 32'h0, 32'd200,
          16'hFFFF, 16'h0000, 16'h0000, 16'd2500, 1'b1}, TYPED, '{1'b1, 3'd1, 8'h01}},
      '{'{FUNC_SELECT, 3'd2, QTY_TIMEOUT, 8'h00, 32'h0, 32'd0,
          16'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0}, TYPED, '{1'b1, 3'd2, 8'h00}},
      // Upper current trips one above its limit
      '{'{FUNC_MEASURE, 3'd0, QTY_TIMEOUT, 8'h00, 32'h0, 32'd300,
          16'd3000, 16'd1001, 16'h0000, 16'd2500, 1'b1}, TYPED, '{1'b1, 3'd1, 8'h01}},
      '{'{FUNC_SELECT, 3'd2, QTY_TIMEOUT, 8'h00, 32'h0, 32'd0,
          16'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0}, TYPED, '{1'b1, 3'd2, 8'h00}},
      // Lower temperature trips at the most negative reading
      '{'{FUNC_MEASURE, 3'd0, QTY_TIMEOUT, 8'h00, 32'h0, 32'd400,
          16'd3000, 16'h0000, 16'h0000, 16'h8000, 1'b1}, TYPED, '{1'b1, 3'd1, 8'h01}},
      '{'{FUNC_SELECT, 3'd2, QTY_TIMEOUT, 8'h00, 32'h0, 32'd0,
          16'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0}, TYPED, '{1'b1, 3'd2, 8'h00}},
      // Lower voltage trips one below its limit
      '{'{FUNC_MEASURE, 3'd0, QTY_TIMEOUT, 8'h00, 32'h0, 32'd500,
          16'd999, 16'h0000, 16'h0000, 16'd2500, 1'b1}, TYPED, '{1'b1, 3'd1, 8'h01}},
      // Timeout write to the active entry must not re-arm the deadline
      '{'{FUNC_WR_UPPER, 3'd1, QTY_TIMEOUT, 8'h05, 32'd1000, 32'd0,
          16'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0}, TYPED, '{1'b0, 3'd1, 8'h00}},
      // Out-of-range quantity: write dropped
      '{'{FUNC_WR_UPPER, 3'd1, QTY_BAD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}, TYPED, '{1'b0, 3'd1, 8'h00}},
      // Lower timeout is stored but never checked
      '{'{FUNC_WR_LOWER, 3'd1, QTY_TIMEOUT, 8'hFF, 32'h0, 32'd0,
          16'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0}, TYPED, '{1'b0, 3'd1, 8'h00}},
      '{'{FUNC_SELECT, 3'd1, QTY_TIMEOUT, 8'h00, 32'h0, 32'd0,
          16'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0}, TYPED, '{1'b1, 3'd1, 8'h00}},
      // Deadline boundary: exactly at, then one past
      '{'{FUNC_MEASURE, 3'd0, QTY_TIMEOUT, 8'h00, 32'h0, 32'd1500,
          16'd3000, 16'h0000, 16'h0000, 16'd2500, 1'b1}, PREDICTED, ANY_RSP},
      '{'{FUNC_MEASURE, 3'd0, QTY_TIMEOUT, 8'h00, 32'h0, 32'd1501,
          16'd3000, 16'h0000, 16'h0000, 16'd2500, 1'b1}, PREDICTED, ANY_RSP},
      // Action byte above ENTRIES, limit at the signed minimum
      '{'{FUNC_WR_UPPER, 3'd5, QTY_CURRENT, 8'h83, 32'hFFFF_8000, 32'd0,
          16'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0}, PREDICTED, ANY_RSP},
      '{'{FUNC_MEASURE, 3'd0, QTY_TIMEOUT, 8'h00, 32'h0, 32'd1600,
          16'd3000, 16'h8000, 16'h0000, 16'd2500, 1'b1}, PREDICTED, ANY_RSP},
      '{'{FUNC_MEASURE, 3'd0, QTY_TIMEOUT, 8'h00, 32'h0, 32'd1700,
          16'd3000, 16'h8001, 16'h0000, 16'd2500, 1'b1}, PREDICTED, ANY_RSP},
      '{'{FUNC_WR_LOWER, 3'd3, QTY_CHARGE, 8'hFF, 32'h0000_7FFF, 32'd0,
          16'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0}, PREDICTED, ANY_RSP},
      '{'{FUNC_MEASURE, 3'd0, QTY_TIMEOUT, 8'h00, 32'h0, 32'd1800,
          16'd3000, 16'h0000, 16'h7FFE, 16'd2500, 1'b1}, PREDICTED, ANY_RSP},
      '{'{FUNC_WR_UPPER, 3'd7, QTY_CHARGE, 8'h08, 32'h0000_8000, 32'd0,
          16'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0}, PREDICTED, ANY_RSP},
      '{'{FUNC_WR_UPPER, 3'd7, QTY_TEMP, 8'h02, 32'h0, 32'd0,
          16'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0}, PREDICTED, ANY_RSP},
      // Charge at the minimum does not exceed a minimum limit; temperature does
      '{'{FUNC_MEASURE, 3'd0, QTY_TIMEOUT, 8'h00, 32'h0, 32'hFFFF_FFFF,
          16'd3000, 16'h0000, 16'h8000, 16'h7FFF, 1'b1}, PREDICTED, ANY_RSP},
      // Time wraps to zero; the re-armed deadline wrapped with it
      '{'{FUNC_MEASURE, 3'd0, QTY_TIMEOUT, 8'h00, 32'h0, 32'd0,
          16'd3000, 16'h0000, 16'h0000, 16'd2500, 1'b1}, PREDICTED, ANY_RSP},
      '{'{FUNC_WR_UPPER, 3'd2, QTY_TIMEOUT, 8'h04, 32'd10, 32'd0,
          16'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0}, PREDICTED, ANY_RSP}
   };

   limit_table_charge_scheduler_top #(
      .ENTRIES(ENTRIES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int slot_of(int e, int side, int q);
      return e * SLOTS_PER_ROW + side * SIDE_SLOTS + q;
   endfunction

   function automatic void switch_entry(int e);
      sched_entry       = e % ENTRIES;
      sched_deadline_ms = sched_last_ms
                          + limit_value_tbl[slot_of(sched_entry, SIDE_UPPER, int'(QTY_TIMEOUT))];
   endfunction

   // Advance the scheduler state by one transaction and return its response
   function automatic rsp_type charge_step_outcome(req_type r);
      rsp_type     outcome;
      int          e;
      int          hi;
      int          lo;
      int          s;
      logic [7:0]  trip;
      logic [31:0] margin;
      outcome = '0;
      trip    = 8'h00;
      e       = int'(r.entry) % ENTRIES;
      case (r.func)
         FUNC_WR_UPPER, FUNC_WR_LOWER: begin
            if (r.quantity < QTY_COUNT) begin
               s = slot_of(e, (r.func == FUNC_WR_LOWER) ? SIDE_LOWER : SIDE_UPPER,
                           int'(r.quantity));
               limit_action_tbl[s] = r.limit_action;
               limit_value_tbl[s]  = r.limit_value;
            end
         end
         FUNC_SELECT: begin
            switch_entry(e);
            outcome.switched = 1'b1;
         end
         default: begin
            sched_last_ms = r.now_ms;
            if (r.ac_present) begin
               hi     = slot_of(sched_entry, SIDE_UPPER, 0);
               lo     = slot_of(sched_entry, SIDE_LOWER, 0);
               margin = sched_deadline_ms - r.now_ms;
               // Fixed priority: deadline, upper limits, then lower limits
               if (limit_action_tbl[hi + QTY_TIMEOUT] != 0 && margin[31])
                  trip = limit_action_tbl[hi + QTY_TIMEOUT];
               else if (limit_action_tbl[hi + QTY_VOLT] != 0
                        && r.volt_mv > limit_value_tbl[hi + QTY_VOLT][15:0])
                  trip = limit_action_tbl[hi + QTY_VOLT];
               else if (limit_action_tbl[hi + QTY_CURRENT] != 0
                        && r.current_ma > $signed(limit_value_tbl[hi + QTY_CURRENT][15:0]))
                  trip = limit_action_tbl[hi + QTY_CURRENT];
               else if (limit_action_tbl[hi + QTY_CHARGE] != 0
                        && r.charge_raw > $signed(limit_value_tbl[hi + QTY_CHARGE][15:0]))
                  trip = limit_action_tbl[hi + QTY_CHARGE];
               else if (limit_action_tbl[hi + QTY_TEMP] != 0
                        && r.temp_centi > $signed(limit_value_tbl[hi + QTY_TEMP][15:0]))
                  trip = limit_action_tbl[hi + QTY_TEMP];
               else if (limit_action_tbl[lo + QTY_VOLT] != 0
                        && r.volt_mv < limit_value_tbl[lo + QTY_VOLT][15:0])
                  trip = limit_action_tbl[lo + QTY_VOLT];
               else if (limit_action_tbl[lo + QTY_CURRENT] != 0
                        && r.current_ma < $signed(limit_value_tbl[lo + QTY_CURRENT][15:0]))
                  trip = limit_action_tbl[lo + QTY_CURRENT];
               else if (limit_action_tbl[lo + QTY_CHARGE] != 0
                        && r.charge_raw < $signed(limit_value_tbl[lo + QTY_CHARGE][15:0]))
                  trip = limit_action_tbl[lo + QTY_CHARGE];
               else if (limit_action_tbl[lo + QTY_TEMP] != 0
                        && r.temp_centi < $signed(limit_value_tbl[lo + QTY_TEMP][15:0]))
                  trip = limit_action_tbl[lo + QTY_TEMP];
               if (trip != 8'h00) begin
                  switch_entry(int'(trip));
                  outcome.switched = 1'b1;
               end
            end
         end
      endcase
      outcome.active_entry = 3'(sched_entry);
      outcome.trip_action  = trip;
      return outcome;
   endfunction

   // Draw a per-transaction wait; now and then fall into a stretch of back-to-back traffic
   function automatic int draw_wait(inout int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         quiet_left = $urandom_range(20, 80);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   // Readings in the band where the usual limits sit, so compares go both ways
   function automatic logic [15:0] typical_reading(logic [2:0] qty);
      case (qty)
         QTY_VOLT:    return 16'($urandom_range(500, 8000));
         QTY_CURRENT: return 16'($urandom_range(0, 4000) - 2000);
         QTY_CHARGE:  return 16'($urandom_range(0, 6000) - 3000);
         default:     return 16'($urandom_range(0, 7000) - 1000);
      endcase
   endfunction

   function automatic req_type make_random_item();
      req_type item;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < 50)      item.func = FUNC_MEASURE;
      else if (pick < 70) item.func = FUNC_WR_UPPER;
      else if (pick < 85) item.func = FUNC_WR_LOWER;
      else                item.func = FUNC_SELECT;
      // Aim half the writes at the active entry so they matter to the next measurement
      item.entry    = ($urandom_range(0, 1) == 0) ? 3'(sched_entry) : 3'($urandom_range(0, 7));
      item.quantity = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                  : 3'($urandom_range(0, 4));
      item.limit_action = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom());
      item.limit_value  = $urandom();
      if (item.quantity == QTY_TIMEOUT) begin
         if ($urandom_range(0, 4) != 0) item.limit_value = $urandom_range(0, 3000);
      end else if ($urandom_range(0, 3) != 0) begin
         item.limit_value[15:0] = typical_reading(item.quantity);
      end
      // Time mostly creeps forward; sometimes lands on the deadline or jumps anywhere
      pick = $urandom_range(0, 99);
      if (pick < 10)      gen_time_ms = sched_deadline_ms - 32'd1 + $urandom_range(0, 2);
      else if (pick < 15) gen_time_ms = $urandom();
      else                gen_time_ms = gen_time_ms + $urandom_range(0, 400);
      item.now_ms     = gen_time_ms;
      item.volt_mv    = ($urandom_range(0, 9) < 3) ? 16'($urandom()) : typical_reading(QTY_VOLT);
      item.current_ma = ($urandom_range(0, 9) < 3) ? 16'($urandom()) : typical_reading(QTY_CURRENT);
      item.charge_raw = ($urandom_range(0, 9) < 3) ? 16'($urandom()) : typical_reading(QTY_CHARGE);
      item.temp_centi = ($urandom_range(0, 9) < 3) ? 16'($urandom()) : typical_reading(QTY_TEMP);
      item.ac_present = ($urandom_range(0, 99) < 85);
      return item;
   endfunction

   task automatic flag_mismatch(string what, rsp_type want, rsp_type got);
      failure_count++;
      if (failure_count <= REPORT_LIMIT)
         $display("%0t %s: expected switched=%0b entry=%0d trip=%02h, got switched=%0b entry=%0d trip=%02h",
                  $realtime, what, want.switched, want.active_entry, want.trip_action,
                  got.switched, got.active_entry, got.trip_action);
   endtask

   // Offer one transaction at the falling edge, hold it until accepted, then predict it.
   // A typed row replaces the predicted response but still advances the state.
   task automatic send_item(input req_type item, input bit typed, input rsp_type typed_rsp);
      int      gap;
      rsp_type outcome;
      gap = draw_wait(req_quiet_left);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      outcome = charge_step_outcome(item);
      pending_outcomes.push_back(typed ? typed_rsp : outcome);
      accepted_count++;
      // Ask the receiver for its long hold-off once traffic is well under way
      if (accepted_count == PRESSURE_AT) long_hold_pending = 1'b1;
      @(negedge clock);
   endtask

   // Stimulus and end of run
   initial begin
      int counted;
      int d;
      req_type item;
      counted = 0;
      // Load the power-up table: everything zero except the default entry
      for (int i = 0; i < SLOT_COUNT; i++) begin
         limit_action_tbl[i] = 8'h00;
         limit_value_tbl[i]  = 32'h0;
      end
      if (ENTRIES > 2) begin
         d = int'(DEFAULT_ENTRY);
         limit_value_tbl[slot_of(d, SIDE_UPPER, int'(QTY_TIMEOUT))]  = DEFAULT_DELTA;
         limit_action_tbl[slot_of(d, SIDE_UPPER, int'(QTY_VOLT))]    = DEFAULT_ACT;
         limit_value_tbl[slot_of(d, SIDE_UPPER, int'(QTY_VOLT))]     = HI_VOLT_MV;
         limit_action_tbl[slot_of(d, SIDE_UPPER, int'(QTY_CURRENT))] = DEFAULT_ACT;
         limit_value_tbl[slot_of(d, SIDE_UPPER, int'(QTY_CURRENT))]  = HI_CURR_MA;
         limit_action_tbl[slot_of(d, SIDE_UPPER, int'(QTY_TEMP))]    = DEFAULT_ACT;
         limit_value_tbl[slot_of(d, SIDE_UPPER, int'(QTY_TEMP))]     = HI_TEMP_CENTI;
         limit_action_tbl[slot_of(d, SIDE_LOWER, int'(QTY_VOLT))]    = DEFAULT_ACT;
         limit_value_tbl[slot_of(d, SIDE_LOWER, int'(QTY_VOLT))]     = LO_VOLT_MV;
         limit_action_tbl[slot_of(d, SIDE_LOWER, int'(QTY_TEMP))]    = DEFAULT_ACT;
         limit_value_tbl[slot_of(d, SIDE_LOWER, int'(QTY_TEMP))]     = LO_TEMP_CENTI;
      end
      sched_entry       = int'(DEFAULT_ENTRY) % ENTRIES;
      sched_deadline_ms = DEFAULT_DELTA;
      sched_last_ms     = 32'h0;

      // Hold reset from time zero, release it on a falling edge
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

      // Random traffic; dropped writes do not count toward the total
      while (counted < RANDOM_ITEMS) begin
         item = make_random_item();
         send_item(item, PREDICTED, ANY_RSP);
         if (!((item.func == FUNC_WR_UPPER || item.func == FUNC_WR_LOWER)
               && item.quantity >= QTY_COUNT))
            counted++;
      end
      req_valid <= 1'b0;

      // Drain: wait for every outstanding response, then keep watching a while longer for strays
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_outcomes.size() != 0) begin
         failure_count += pending_outcomes.size();
         $display("%0d responses never arrived", pending_outcomes.size());
      end
      if (failure_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Receiver: stall a random count per response, plus one long hold-off to back up
   // the block while the sender keeps offering
   initial begin
      int stall;
      @(negedge clock);
      forever begin
         if (long_hold_pending) begin
            stall             = LONG_HOLD_CYCLES;
            long_hold_pending = 1'b0;
         end else begin
            stall = draw_wait(rsp_quiet_left);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         @(negedge clock);
      end
   end

   // Check each accepted response against the oldest outstanding prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            flag_mismatch("response with no transaction outstanding", ANY_RSP, rsp_data);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_data.switched !== want.switched
                || rsp_data.active_entry !== want.active_entry
                || rsp_data.trip_action !== want.trip_action)
               flag_mismatch("response mismatch", want, rsp_data);
         end
      end
   end

   // Watchdog: drop the run if neither channel moves a transaction for too long
   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_ready === 1'b1)
          || (rsp_valid === 1'b1 && rsp_ready === 1'b1)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

endmodule
